// ----- src/cau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types for the complex arithmetic unit: command codes and the
// control word that travels down the pipeline next to the data.
// ----------------------------------------------------------------------------
package cau_pkg;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_INC = 3'd4,
		CMD_DEC = 3'd5,
		CMD_CMP = 3'd6
	} cau_cmd_t;

	// per-item control; neg/ovf describe the magnitude lanes for mul and div
	typedef struct packed {
		logic     valid;
		cau_cmd_t cmd;
		logic     eq;
		logic     sat;
		logic     dz;
		logic     neg_re;
		logic     neg_im;
		logic     ovf_re;
		logic     ovf_im;
	} cau_ctl_t;

endpackage

// ----- src/cau_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Stages 1 and 2: add/sub/inc/dec/compare with saturation, the four cross
// products and two squares (stage 1), then product sums and |b|^2 (stage 2).
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [2:0]                    command,
	input  logic signed [DATA_WIDTH-1:0]  a_real,
	input  logic signed [DATA_WIDTH-1:0]  a_imag,
	input  logic signed [DATA_WIDTH-1:0]  b_real,
	input  logic signed [DATA_WIDTH-1:0]  b_imag,
	output cau_ctl_t                      ctl_s2,
	output logic signed [DATA_WIDTH-1:0]  pass_re_s2,
	output logic signed [DATA_WIDTH-1:0]  pass_im_s2,
	output logic signed [2*DATA_WIDTH:0]  x_re_s2,
	output logic signed [2*DATA_WIDTH:0]  x_im_s2,
	output logic [2*DATA_WIDTH-1:0]       den_s2
);

	localparam int W = DATA_WIDTH;
	localparam logic signed [W:0] ONE = {{(W-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	// {clamped, value} of a W+1 bit sum
	function automatic logic [W:0] satw(input logic signed [W:0] v);
		if (v[W] != v[W-1])
			satw = v[W] ? {1'b1, 1'b1, {(W-1){1'b0}}} : {1'b1, 1'b0, {(W-1){1'b1}}};
		else
			satw = {1'b0, v[W-1:0]};
	endfunction

	cau_cmd_t cmd;
	logic signed [W:0] ar, ai, br, bi, sum_re, sum_im;
	logic [W:0] sr, si;
	logic eq;
	cau_ctl_t ctl_d, ctl_s1;

	logic signed [2*W-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic [2*W-1:0] sq_r_s1, sq_i_s1;
	logic signed [W-1:0] pass_re_s1, pass_im_s1;

	assign cmd = cau_cmd_t'(command);
	assign ar  = {a_real[W-1], a_real};
	assign ai  = {a_imag[W-1], a_imag};
	assign br  = {b_real[W-1], b_real};
	assign bi  = {b_imag[W-1], b_imag};

	always_comb begin
		sum_re = '0;
		sum_im = '0;
		eq     = 1'b0;
		case (cmd)
			CMD_ADD: begin
				sum_re = ar + br;
				sum_im = ai + bi;
			end
			CMD_SUB: begin
				sum_re = ar - br;
				sum_im = ai - bi;
			end
			CMD_INC: begin
				sum_re = ar + ONE;
				sum_im = ai + ONE;
			end
			CMD_DEC: begin
				sum_re = ar - ONE;
				sum_im = ai - ONE;
			end
			CMD_DIV: begin
				// a rides along for the zero divisor case
				sum_re = ar;
				sum_im = ai;
			end
			CMD_CMP: begin
				eq = (a_real == b_real) && (a_imag == b_imag);
			end
			default: begin
			end
		endcase
	end

	assign sr = satw(sum_re);
	assign si = satw(sum_im);

	always_comb begin
		ctl_d       = '0;
		ctl_d.valid = in_valid;
		ctl_d.cmd   = cmd;
		ctl_d.eq    = eq;
		ctl_d.sat   = sr[W] | si[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_d;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_rr_s1    <= (2*W)'(a_real) * (2*W)'(b_real);
			p_ii_s1    <= (2*W)'(a_imag) * (2*W)'(b_imag);
			p_ri_s1    <= (2*W)'(a_real) * (2*W)'(b_imag);
			p_ir_s1    <= (2*W)'(a_imag) * (2*W)'(b_real);
			sq_r_s1    <= $unsigned((2*W)'(b_real) * (2*W)'(b_real));
			sq_i_s1    <= $unsigned((2*W)'(b_imag) * (2*W)'(b_imag));
			pass_re_s1 <= sr[W-1:0];
			pass_im_s1 <= si[W-1:0];

			// mul: (rr - ii, ri + ir); div numerator: (rr + ii, ir - ri)
			if (ctl_s1.cmd == CMD_MUL) begin
				x_re_s2 <= (2*W+1)'(p_rr_s1) - (2*W+1)'(p_ii_s1);
				x_im_s2 <= (2*W+1)'(p_ri_s1) + (2*W+1)'(p_ir_s1);
			end else begin
				x_re_s2 <= (2*W+1)'(p_rr_s1) + (2*W+1)'(p_ii_s1);
				x_im_s2 <= (2*W+1)'(p_ir_s1) - (2*W+1)'(p_ri_s1);
			end
			den_s2     <= sq_r_s1 + sq_i_s1;
			pass_re_s2 <= pass_re_s1;
			pass_im_s2 <= pass_im_s1;
		end
	end

endmodule

// ----- src/cau_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_prep
// Stage 3: sign/magnitude split. Mul magnitude is truncated here; div gets
// its starting remainder, low numerator bits, overflow and zero checks.
// ----------------------------------------------------------------------------
module cau_prep import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  cau_ctl_t                      ctl_s2,
	input  logic signed [DATA_WIDTH-1:0]  pass_re_s2,
	input  logic signed [DATA_WIDTH-1:0]  pass_im_s2,
	input  logic signed [2*DATA_WIDTH:0]  x_re_s2,
	input  logic signed [2*DATA_WIDTH:0]  x_im_s2,
	input  logic [2*DATA_WIDTH-1:0]       den_s2,
	output cau_ctl_t                      ctl_s3,
	output logic signed [DATA_WIDTH-1:0]  pass_re_s3,
	output logic signed [DATA_WIDTH-1:0]  pass_im_s3,
	output logic [2*DATA_WIDTH-1:0]       rem_re_s3,
	output logic [2*DATA_WIDTH-1:0]       rem_im_s3,
	output logic [DATA_WIDTH-1:0]         nlo_re_s3,
	output logic [DATA_WIDTH-1:0]         nlo_im_s3,
	output logic [2*DATA_WIDTH-1:0]       den_s3
);

	localparam int W = DATA_WIDTH;
	localparam int F = FRAC_BITS;

	logic [2*W:0] mag_re, mag_im, sh_re, sh_im;
	logic [2*W-1:0] r0_re, r0_im;
	cau_ctl_t ctl_d;
	logic signed [W-1:0] pass_re_d, pass_im_d;

	assign mag_re = x_re_s2[2*W] ? $unsigned(-x_re_s2) : $unsigned(x_re_s2);
	assign mag_im = x_im_s2[2*W] ? $unsigned(-x_im_s2) : $unsigned(x_im_s2);
	assign sh_re  = mag_re >> F;
	assign sh_im  = mag_im >> F;
	// quotient bits start at 2^(W-1); remainder holds numerator >> W
	assign r0_re  = mag_re[2*W-1:0] >> (W-F);
	assign r0_im  = mag_im[2*W-1:0] >> (W-F);

	always_comb begin
		ctl_d     = ctl_s2;
		pass_re_d = pass_re_s2;
		pass_im_d = pass_im_s2;
		case (ctl_s2.cmd)
			CMD_MUL: begin
				ctl_d.neg_re = x_re_s2[2*W];
				ctl_d.neg_im = x_im_s2[2*W];
				ctl_d.ovf_re = |sh_re[2*W:W];
				ctl_d.ovf_im = |sh_im[2*W:W];
				pass_re_d    = sh_re[W-1:0];
				pass_im_d    = sh_im[W-1:0];
			end
			CMD_DIV: begin
				ctl_d.neg_re = x_re_s2[2*W];
				ctl_d.neg_im = x_im_s2[2*W];
				// quotient reaches 2^W exactly when starting remainder >= divisor
				ctl_d.ovf_re = r0_re >= den_s2;
				ctl_d.ovf_im = r0_im >= den_s2;
				ctl_d.dz     = den_s2 == '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s3 <= '0;
		else if (en)
			ctl_s3 <= ctl_d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_re_s3 <= pass_re_d;
			pass_im_s3 <= pass_im_d;
			rem_re_s3  <= r0_re;
			rem_im_s3  <= r0_im;
			nlo_re_s3  <= {mag_re[W-F-1:0], {F{1'b0}}};
			nlo_im_s3  <= {mag_im[W-F-1:0], {F{1'b0}}};
			den_s3     <= den_s2;
		end
	end

endmodule

// ----- src/cau_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_step
// One registered restoring-division stage: one quotient bit for each of the
// real and imaginary lanes against the shared |b|^2.
// ----------------------------------------------------------------------------
module cau_div_step import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  cau_ctl_t                      ctl_in,
	input  logic signed [DATA_WIDTH-1:0]  pass_re_in,
	input  logic signed [DATA_WIDTH-1:0]  pass_im_in,
	input  logic [2*DATA_WIDTH-1:0]       rem_re_in,
	input  logic [2*DATA_WIDTH-1:0]       rem_im_in,
	input  logic [DATA_WIDTH-1:0]         nlo_re_in,
	input  logic [DATA_WIDTH-1:0]         nlo_im_in,
	input  logic [DATA_WIDTH-1:0]         q_re_in,
	input  logic [DATA_WIDTH-1:0]         q_im_in,
	input  logic [2*DATA_WIDTH-1:0]       den_in,
	output cau_ctl_t                      ctl_out,
	output logic signed [DATA_WIDTH-1:0]  pass_re_out,
	output logic signed [DATA_WIDTH-1:0]  pass_im_out,
	output logic [2*DATA_WIDTH-1:0]       rem_re_out,
	output logic [2*DATA_WIDTH-1:0]       rem_im_out,
	output logic [DATA_WIDTH-1:0]         nlo_re_out,
	output logic [DATA_WIDTH-1:0]         nlo_im_out,
	output logic [DATA_WIDTH-1:0]         q_re_out,
	output logic [DATA_WIDTH-1:0]         q_im_out,
	output logic [2*DATA_WIDTH-1:0]       den_out
);

	localparam int W = DATA_WIDTH;

	logic [2*W-1:0] t_re, t_im;
	logic take_re, take_im;

	assign t_re    = {rem_re_in[2*W-2:0], nlo_re_in[W-1]};
	assign t_im    = {rem_im_in[2*W-2:0], nlo_im_in[W-1]};
	assign take_re = t_re >= den_in;
	assign take_im = t_im >= den_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_out <= '0;
		else if (en)
			ctl_out <= ctl_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_re_out <= pass_re_in;
			pass_im_out <= pass_im_in;
			rem_re_out  <= take_re ? t_re - den_in : t_re;
			rem_im_out  <= take_im ? t_im - den_in : t_im;
			nlo_re_out  <= {nlo_re_in[W-2:0], 1'b0};
			nlo_im_out  <= {nlo_im_in[W-2:0], 1'b0};
			q_re_out    <= {q_re_in[W-2:0], take_re};
			q_im_out    <= {q_im_in[W-2:0], take_im};
			den_out     <= den_in;
		end
	end

endmodule

// ----- src/complex_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex ALU on signed fixed-point pairs: add, sub, mul, div, inc, dec and
// compare, with saturation and divide-by-zero reporting.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            word
//  req      in   req_valid/req_stall  command, a_real, a_imag, b_real, b_imag
//  rsp      out  rsp_valid/rsp_stall  res_real, res_imag, div_by_zero,
//                                     is_equal, saturated
//
//  One word accepted per cycle while the output is not stalled; every
//  command passes the same stages; the divider gives one quotient bit per stage.
//  Stages: 1 products/simple ops, 2 sums and |b|^2, 3 sign split, then
//  DATA_WIDTH division steps, then the output register.
//  A stalled output freezes the whole pipe; nothing is dropped or repeated.
//  Reset clears only the control words and the output valid; no clearing pass.
//
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [2:0]                    command,
	input  logic signed [DATA_WIDTH-1:0]  a_real,
	input  logic signed [DATA_WIDTH-1:0]  a_imag,
	input  logic signed [DATA_WIDTH-1:0]  b_real,
	input  logic signed [DATA_WIDTH-1:0]  b_imag,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic signed [DATA_WIDTH-1:0]  res_real,
	output logic signed [DATA_WIDTH-1:0]  res_imag,
	output logic                          div_by_zero,
	output logic                          is_equal,
	output logic                          saturated
);

	localparam int W = DATA_WIDTH;

	// magnitude + sign -> {clamped, two's complement value}
	function automatic logic [W:0] fmt(input logic [W-1:0] q, input logic neg,
			input logic ovf);
		logic [W-1:0] lim;
		lim = {1'b1, {(W-1){1'b0}}};
		if (ovf)
			fmt = neg ? {1'b1, lim} : {1'b1, ~lim};
		else if (neg)
			fmt = (q > lim) ? {1'b1, lim} : {1'b0, -q};
		else
			fmt = q[W-1] ? {1'b1, ~lim} : {1'b0, q};
	endfunction

	logic adv;

	// stage 2 -> 3
	cau_ctl_t ctl_s2;
	logic signed [W-1:0] pass_re_s2, pass_im_s2;
	logic signed [2*W:0] x_re_s2, x_im_s2;
	logic [2*W-1:0] den_s2;

	// division chain, index 0 is stage 3, index W is the last division step
	cau_ctl_t            ctl_d   [0:W];
	logic signed [W-1:0] pass_re [0:W];
	logic signed [W-1:0] pass_im [0:W];
	logic [2*W-1:0]      rem_re  [0:W];
	logic [2*W-1:0]      rem_im  [0:W];
	logic [W-1:0]        nlo_re  [0:W];
	logic [W-1:0]        nlo_im  [0:W];
	logic [W-1:0]        q_re    [0:W];
	logic [W-1:0]        q_im    [0:W];
	logic [2*W-1:0]      den     [0:W];

	cau_ctl_t ctl_w;
	logic [W:0] f_re, f_im;
	logic signed [W-1:0] o_re, o_im;
	logic o_sat;

	logic rsp_valid_q, dz_q, eq_q, sat_q;
	logic signed [W-1:0] re_q, im_q;

	// whole pipe moves unless the output word is held
	assign adv       = !(rsp_valid_q && rsp_stall);
	assign req_stall = !adv;

	cau_front #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_valid   (req_valid),
		.command    (command),
		.a_real     (a_real),
		.a_imag     (a_imag),
		.b_real     (b_real),
		.b_imag     (b_imag),
		.ctl_s2     (ctl_s2),
		.pass_re_s2 (pass_re_s2),
		.pass_im_s2 (pass_im_s2),
		.x_re_s2    (x_re_s2),
		.x_im_s2    (x_im_s2),
		.den_s2     (den_s2)
	);

	cau_prep #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.ctl_s2     (ctl_s2),
		.pass_re_s2 (pass_re_s2),
		.pass_im_s2 (pass_im_s2),
		.x_re_s2    (x_re_s2),
		.x_im_s2    (x_im_s2),
		.den_s2     (den_s2),
		.ctl_s3     (ctl_d[0]),
		.pass_re_s3 (pass_re[0]),
		.pass_im_s3 (pass_im[0]),
		.rem_re_s3  (rem_re[0]),
		.rem_im_s3  (rem_im[0]),
		.nlo_re_s3  (nlo_re[0]),
		.nlo_im_s3  (nlo_im[0]),
		.den_s3     (den[0])
	);

	assign q_re[0] = '0;
	assign q_im[0] = '0;

	for (genvar g = 0; g < W; g++) begin : g_div
		cau_div_step #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_step (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (adv),
			.ctl_in      (ctl_d[g]),
			.pass_re_in  (pass_re[g]),
			.pass_im_in  (pass_im[g]),
			.rem_re_in   (rem_re[g]),
			.rem_im_in   (rem_im[g]),
			.nlo_re_in   (nlo_re[g]),
			.nlo_im_in   (nlo_im[g]),
			.q_re_in     (q_re[g]),
			.q_im_in     (q_im[g]),
			.den_in      (den[g]),
			.ctl_out     (ctl_d[g+1]),
			.pass_re_out (pass_re[g+1]),
			.pass_im_out (pass_im[g+1]),
			.rem_re_out  (rem_re[g+1]),
			.rem_im_out  (rem_im[g+1]),
			.nlo_re_out  (nlo_re[g+1]),
			.nlo_im_out  (nlo_im[g+1]),
			.q_re_out    (q_re[g+1]),
			.q_im_out    (q_im[g+1]),
			.den_out     (den[g+1])
		);
	end

	// final formatting: mul magnitude rides in the pass lanes, div in q
	assign ctl_w = ctl_d[W];

	always_comb begin
		f_re  = '0;
		f_im  = '0;
		o_re  = pass_re[W];
		o_im  = pass_im[W];
		o_sat = ctl_w.sat;
		case (ctl_w.cmd)
			CMD_MUL: begin
				f_re  = fmt(pass_re[W], ctl_w.neg_re, ctl_w.ovf_re);
				f_im  = fmt(pass_im[W], ctl_w.neg_im, ctl_w.ovf_im);
				o_re  = f_re[W-1:0];
				o_im  = f_im[W-1:0];
				o_sat = f_re[W] | f_im[W];
			end
			CMD_DIV: begin
				if (ctl_w.dz) begin
					o_sat = 1'b0;
				end else begin
					f_re  = fmt(q_re[W], ctl_w.neg_re, ctl_w.ovf_re);
					f_im  = fmt(q_im[W], ctl_w.neg_im, ctl_w.ovf_im);
					o_re  = f_re[W-1:0];
					o_im  = f_im[W-1:0];
					o_sat = f_re[W] | f_im[W];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (adv)
			rsp_valid_q <= ctl_w.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			re_q  <= o_re;
			im_q  <= o_im;
			dz_q  <= ctl_w.dz;
			eq_q  <= ctl_w.eq;
			sat_q <= o_sat;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign res_real    = re_q;
	assign res_imag    = im_q;
	assign div_by_zero = dz_q;
	assign is_equal    = eq_q;
	assign saturated   = sat_q;

	// input is held back only while a finished word waits
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("req_stall without a held output word");

	// a zero divisor never reports clamping or equality
	a_dz_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && div_by_zero) |-> (!saturated && !is_equal))
		else $error("div_by_zero with other flags set");

	// compare results carry zero parts and no clamping
	a_eq_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && is_equal) |-> (!saturated && res_real == '0 && res_imag == '0))
		else $error("is_equal word has nonzero parts or clamping");

	// a free output register always takes what the last stage offers
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp_valid && ctl_w.valid) |=> rsp_valid)
		else $error("valid word lost at the output register");

endmodule
